[rtl/hybrid_jacobi_gauss_seidel_solver_core_macros.svh]
// assertion helpers
`ifndef HYBRID_JACOBI_GAUSS_SEIDEL_SOLVER_CORE_MACROS_SVH
`define HYBRID_JACOBI_GAUSS_SEIDEL_SOLVER_CORE_MACROS_SVH
`define HJGS_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define HJGS_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[rtl/hjgs_pkg.sv]
package hjgs_pkg;
    localparam int unsigned CMD_W = 2;
    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_SOLVE  = 2'd2;
    localparam logic [1:0] REG_SIZE   = 2'd0;
    localparam logic [1:0] REG_THRESH = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic               converged;
        logic [15:0]        sweeps_used;
    } t_out_beat;

    // request/response between sequencer and the divider
    typedef struct packed {
        logic               start;
        logic signed [31:0] resid;
        logic signed [31:0] diag;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;
endpackage

[rtl/hjgs_div.sv]
// Sequential signed divider: (resid << FRAC_BITS) / diag, truncate toward zero,
// saturate to 32 bits. One quotient bit per cycle.
module hjgs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hjgs_pkg::t_div_req i_req,
    output hjgs_pkg::t_div_rsp o_rsp
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_num, n_num;
    logic [31:0]   r_den, n_den;
    logic [32:0]   r_rem, n_rem;
    logic          r_neg, n_neg;
    logic          r_done, n_done;
    logic signed [31:0] r_quot, n_quot;

    logic [31:0]   abs_r, abs_d;
    logic [32:0]   shl;
    logic [NW:0]   qmag;

    always_comb begin
        abs_r = i_req.resid[31] ? 32'(-i_req.resid) : 32'(i_req.resid);
        abs_d = i_req.diag[31] ? 32'(-i_req.diag) : 32'(i_req.diag);
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_neg  = r_neg;
        n_done = 1'b0;
        n_quot = r_quot;
        shl    = {r_rem[31:0], r_num[NW-1]};
        qmag   = '0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NW);
            n_num  = {abs_r, {FRAC_BITS{1'b0}}};
            n_den  = abs_d;
            n_rem  = '0;
            n_neg  = i_req.resid[31] ^ i_req.diag[31];
        end else if (r_busy) begin
            // quotient bits shift into the low end of r_num
            if (shl >= {1'b0, r_den}) begin
                n_rem = shl - {1'b0, r_den};
                n_num = {r_num[NW-2:0], 1'b1};
            end else begin
                n_rem = shl;
                n_num = {r_num[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                qmag = {1'b0, n_num};
                if (r_neg) begin
                    if (qmag > (NW+1)'(33'h080000000)) n_quot = 32'sh80000000;
                    else n_quot = 32'(-qmag);
                end else begin
                    if (qmag > (NW+1)'(33'h07FFFFFFF)) n_quot = 32'sh7FFFFFFF;
                    else n_quot = 32'(qmag);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

[rtl/hybrid_jacobi_gauss_seidel_solver_core.sv]
// Hybrid Jacobi / Gauss-Seidel solver, signed Q16.16.
// Input channel (i_in_valid/o_in_stall, payload i_in): cmd 0 loads A[row][col],
// cmd 1 loads b[row]; cmd 2 starts a solve from x = 0.
// A sweep updates odd rows from the old x, commits them, then updates even
// rows in place. Each row has a setup, a multiply-accumulate (one 32x32
// multiplier, one product per cycle, registered), a division in the
// bit-serial divider and an update; the solve runs until summed squared
// change <= threshold or the sweep limit.
// Results: n beats on o_out_valid/i_out_stall, x[0..n-1], last on x[n-1],
// one beat per cycle when not stalled. o_in_stall stays high from solve
// start until the last result beat leaves. A stalled result holds.
// Config port (i_cfg_valid/o_cfg_ready, i_cfg_addr, i_cfg_data) is always
// ready; write only while idle. Reset (synchronous, i_rst_n low) restores
// size 16, threshold 1, limit 1000 and clears x; A and b are undefined
// until loaded.
`include "hybrid_jacobi_gauss_seidel_solver_core_macros.svh"
module hybrid_jacobi_gauss_seidel_solver_core #(
    parameter int MAX_EQUATIONS = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hjgs_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hjgs_pkg::t_out_beat o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_data
);
    localparam int IW = $clog2(MAX_EQUATIONS);
    localparam int CW = $clog2(MAX_EQUATIONS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ROWST = 9'b000000010,
        S_MAC   = 9'b000000100,
        S_RESID = 9'b000001000,
        S_DIVW  = 9'b000010000,
        S_CHG   = 9'b000100000,
        S_COMMIT= 9'b001000000,
        S_CHECK = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic signed [31:0] r_a [MAX_EQUATIONS*MAX_EQUATIONS];
    logic signed [31:0] r_b [MAX_EQUATIONS];
    logic signed [31:0] r_x [MAX_EQUATIONS];
    logic signed [31:0] r_ob [(MAX_EQUATIONS+1)/2];

    logic [4:0]  r_size;
    logic [30:0] r_thresh;
    logic [15:0] r_limit;

    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;     // current row
    logic [CW-1:0] r_j;     // column being fetched
    logic          r_even;  // phase: 0 odd rows, 1 even rows
    logic          r_pv, r_av, r_mv;  // fetch, operand and product valid
    logic [IW-1:0] r_pj;
    logic signed [31:0] r_aij, r_xj, r_diag, r_bi;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_sum;
    logic [31:0]   r_csum;
    logic [15:0]   r_sweeps;
    logic          r_conv;
    logic signed [31:0] r_newx;
    logic [63:0]   r_sq;
    logic          r_sqv;
    logic [CW-1:0] r_oi;
    logic          r_ovalid;
    hjgs_pkg::t_out_beat r_out;

    hjgs_pkg::t_div_req div_req;
    hjgs_pkg::t_div_rsp div_rsp;

    logic in_acc, out_acc;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out = r_out;

    hjgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // saturated sum and residual
    logic signed [31:0] sum_sat, resid_sat;
    logic signed [32:0] resid_w;
    always_comb begin
        if (r_sum > 64'sh7FFFFFFF) sum_sat = 32'sh7FFFFFFF;
        else if (r_sum < -64'sh80000000) sum_sat = 32'sh80000000;
        else sum_sat = 32'(r_sum);
        resid_w = 33'(r_bi) - 33'(sum_sat);
        if (resid_w > 33'sh07FFFFFFF) resid_sat = 32'sh7FFFFFFF;
        else if (resid_w < -33'sh080000000) resid_sat = 32'sh80000000;
        else resid_sat = 32'(resid_w);
    end

    logic div_zero;
    assign div_zero = (r_diag == 32'sd0);
    assign div_req.start = (r_state == S_RESID) && !div_zero;
    assign div_req.resid = resid_sat;
    assign div_req.diag  = r_diag;

    logic [IW-1:0] ii;
    assign ii = r_i[IW-1:0];

    // change square from r_x[ii] and r_newx
    logic signed [32:0] dlt;
    logic [32:0] mag;
    assign dlt = 33'(r_x[ii]) - 33'(r_newx);
    assign mag = dlt[32] ? 33'(-dlt) : dlt;

    logic [63:0] sqf;
    logic [32:0] csum_w;
    always_comb begin
        sqf = r_sq >> FRAC_BITS;
        if (sqf > 64'hFFFFFFFF) sqf = 64'hFFFFFFFF;
        csum_w = {1'b0, r_csum} + {1'b0, sqf[31:0]};
    end

    logic [CW-1:0] next_row;
    logic          row_wrap;
    assign next_row = r_i + CW'(2);
    assign row_wrap = (next_row >= r_n);

    logic [IW-1:0] jj;
    assign jj = r_j[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.cmd == hjgs_pkg::CMD_LOAD_A
                && 32'(i_in.row) < MAX_EQUATIONS && 32'(i_in.col) < MAX_EQUATIONS)
            r_a[(IW+IW)'(i_in.row) * (IW+IW)'(MAX_EQUATIONS) + (IW+IW)'(i_in.col)]
                <= i_in.value;
        if (in_acc && i_in.cmd == hjgs_pkg::CMD_LOAD_B && 32'(i_in.row) < MAX_EQUATIONS)
            r_b[IW'(i_in.row)] <= i_in.value;
        if (r_pv) begin
            r_aij <= r_a[(IW+IW)'(ii) * (IW+IW)'(MAX_EQUATIONS) + (IW+IW)'(r_pj)];
            r_xj  <= r_x[r_pj];
        end
        if (r_state == S_ROWST) begin
            r_diag <= r_a[(IW+IW)'(ii) * (IW+IW)'(MAX_EQUATIONS) + (IW+IW)'(ii)];
            r_bi   <= r_b[ii];
        end
        r_prod <= r_aij * r_xj;
        r_sq   <= 64'(mag[31:0]) * 64'(mag[31:0]);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc && i_in.cmd == hjgs_pkg::CMD_SOLVE) n_state = S_ROWST;
            S_ROWST:  n_state = S_MAC;
            S_MAC:    if (!r_pv && !r_av && !r_mv && r_j >= r_n) n_state = S_RESID;
            S_RESID:  n_state = div_zero ? S_CHG : S_DIVW;
            S_DIVW:   if (div_rsp.done) n_state = S_CHG;
            S_CHG:    if (r_sqv) begin
                if (!row_wrap) n_state = S_ROWST;
                else if (!r_even) n_state = S_COMMIT;
                else n_state = S_CHECK;
            end
            S_COMMIT: n_state = S_ROWST;
            S_CHECK:  if (r_csum <= {1'b0, r_thresh} || r_sweeps >= r_limit
                          || r_limit == 16'd0) n_state = S_OUT;
                      else n_state = (r_n > CW'(1)) ? S_ROWST : S_ROWST;
            S_OUT:    if (out_acc && r_out.last) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= 5'd16;
            r_thresh <= 31'd1;
            r_limit  <= 16'd1000;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
            r_av     <= 1'b0;
            r_mv     <= 1'b0;
            r_sqv    <= 1'b0;
            for (int k = 0; k < MAX_EQUATIONS; k++) r_x[k] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    hjgs_pkg::REG_SIZE:   r_size   <= i_cfg_data[4:0];
                    hjgs_pkg::REG_THRESH: r_thresh <= i_cfg_data[30:0];
                    hjgs_pkg::REG_LIMIT:  r_limit  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            r_pv  <= 1'b0;
            r_av  <= r_pv;
            r_mv  <= r_av;
            r_sqv <= 1'b0;
            case (r_state)
                S_IDLE: if (in_acc && i_in.cmd == hjgs_pkg::CMD_SOLVE) begin
                    for (int k = 0; k < MAX_EQUATIONS; k++) r_x[k] <= '0;
                    if (r_size == 5'd0) r_n <= CW'(1);
                    else if (32'(r_size) > MAX_EQUATIONS) r_n <= CW'(MAX_EQUATIONS);
                    else r_n <= CW'(r_size);
                    r_sweeps <= '0;
                    r_csum   <= '0;
                    // an n of 1 has no odd rows: start directly with row 0
                    if (r_size == 5'd1 || r_size == 5'd0) begin
                        r_even <= 1'b1;
                        r_i    <= '0;
                    end else begin
                        r_even <= 1'b0;
                        r_i    <= CW'(1);
                    end
                end
                S_ROWST: begin
                    r_sum <= '0;
                    r_j   <= '0;
                end
                S_MAC: begin
                    if (r_j < r_n) begin
                        if (r_j != r_i) begin
                            r_pv <= 1'b1;
                            r_pj <= jj;
                        end
                        r_j <= r_j + 1'b1;
                    end
                    if (r_mv) r_sum <= r_sum + (r_prod >>> FRAC_BITS);
                end
                S_RESID: if (div_zero) begin
                    if (resid_sat > 0) r_newx <= 32'sh7FFFFFFF;
                    else if (resid_sat < 0) r_newx <= 32'sh80000000;
                    else r_newx <= '0;
                    r_sqv <= 1'b0;
                end
                S_DIVW: if (div_rsp.done) r_newx <= div_rsp.quot;
                default: ;
            endcase
            if ((r_state == S_CHG) && !r_sqv) begin
                r_sqv <= 1'b1;
            end
            if (r_state == S_CHG && r_sqv) begin
                if (mag[32]) r_csum <= 32'hFFFFFFFF;
                else r_csum <= csum_w[32] ? 32'hFFFFFFFF : csum_w[31:0];
                if (r_even) r_x[ii] <= r_newx;
                else r_ob[ii[IW-1:1]] <= r_newx;
                if (row_wrap && !r_even) begin
                    r_even <= 1'b1;
                    r_i    <= '0;
                end else if (row_wrap) begin
                    r_sweeps <= r_sweeps + 1'b1;
                end else begin
                    r_i <= next_row;
                end
            end
            if (r_state == S_COMMIT) begin
                for (int k = 1; k < MAX_EQUATIONS; k += 2)
                    if (CW'(k) < r_n) r_x[k] <= r_ob[k/2];
            end
            if (r_state == S_CHECK) begin
                if (r_csum <= {1'b0, r_thresh}) r_conv <= 1'b1;
                else r_conv <= 1'b0;
                r_csum <= '0;
                if (r_n > CW'(1)) begin
                    r_even <= 1'b0;
                    r_i    <= CW'(1);
                end else begin
                    r_even <= 1'b1;
                    r_i    <= '0;
                end
                r_oi <= '0;
            end
            if (r_state == S_OUT && (!r_ovalid || out_acc) && !(r_ovalid && r_out.last)) begin
                r_ovalid <= 1'b1;
                r_out.index       <= 4'(r_oi);
                r_out.solution    <= r_x[r_oi[IW-1:0]];
                r_out.last        <= (r_oi + 1'b1 == r_n);
                r_out.converged   <= r_conv;
                r_out.sweeps_used <= r_sweeps;
                r_oi <= r_oi + 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    `HJGS_ASSERT_IMP(a_out_in_solve, i_clk, i_rst_n, o_out_valid, r_state == S_OUT,
        "result beat outside output phase")
    `HJGS_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall,
        "input accepted while busy")
    `HJGS_ASSERT_NXT(a_last_done, i_clk, i_rst_n, out_acc && o_out.last, r_state == S_IDLE,
        "did not return to idle after last beat")
endmodule

[tb/tb_hybrid_jacobi_gauss_seidel_solver_core.sv]
module tb_hybrid_jacobi_gauss_seidel_solver_core;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT   = 150000;
    localparam int DRAIN_CYCLES     = 30;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        typed;
        logic [31:0] x0;
    } t_dir_row;

    // size 1 system: diagonal, zero diagonal, extreme values, unused command
    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{hjgs_pkg::CMD_LOAD_A, 4'd0, 4'd0, 32'h0001_0000, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_LOAD_B, 4'd0, 4'd0, 32'h0000_0100, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_SOLVE,  4'd0, 4'd0, 32'h0,         1'b1, 32'h0000_0100},
        '{hjgs_pkg::CMD_LOAD_B, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_SOLVE,  4'd0, 4'd0, 32'h0,         1'b1, 32'h7FFF_FFFF},
        '{hjgs_pkg::CMD_LOAD_A, 4'd0, 4'd0, 32'h0,         1'b0, 32'h0},
        '{hjgs_pkg::CMD_SOLVE,  4'd0, 4'd0, 32'h0,         1'b1, 32'h7FFF_FFFF},
        '{hjgs_pkg::CMD_LOAD_B, 4'd0, 4'd0, 32'h8000_0000, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_SOLVE,  4'd0, 4'd0, 32'h0,         1'b1, 32'h8000_0000},
        '{hjgs_pkg::CMD_LOAD_B, 4'd0, 4'd0, 32'h0,         1'b0, 32'h0},
        '{hjgs_pkg::CMD_SOLVE,  4'd0, 4'd0, 32'h0,         1'b1, 32'h0},
        '{CMD_NONE,             4'hF, 4'hF, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_LOAD_A, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_LOAD_B, 4'd0, 4'd0, 32'h8000_0000, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_SOLVE,  4'd0, 4'd0, 32'h0,         1'b0, 32'h0},
        '{hjgs_pkg::CMD_LOAD_A, 4'd0, 4'd0, 32'h8000_0000, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_LOAD_B, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_SOLVE,  4'd0, 4'd0, 32'h0,         1'b0, 32'h0},
        '{hjgs_pkg::CMD_LOAD_A, 4'hF, 4'hF, 32'h1234_5678, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_LOAD_A, 4'd0, 4'd0, 32'hFFFF_0000, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_LOAD_B, 4'd0, 4'd0, 32'h0003_0000, 1'b0, 32'h0},
        '{hjgs_pkg::CMD_SOLVE,  4'd0, 4'd0, 32'h0,         1'b1, 32'hFFFD_0000}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    hjgs_pkg::t_in_beat  in_beat = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    hjgs_pkg::t_out_beat o_out;
    logic      cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_data = '0;

    always #2 i_clk = ~i_clk;

    hybrid_jacobi_gauss_seidel_solver_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    // solver state mirrored from accepted beats
    logic signed [31:0] a_mat [16][16];
    logic signed [31:0] b_vec [16];
    logic signed [31:0] x_est [16];
    bit          a_wr [16][16];
    bit          b_wr [16];
    logic [4:0]  size_reg  = 5'd16;
    logic [30:0] thresh_reg = 31'd1;
    logic [15:0] limit_reg = 16'd1000;

    hjgs_pkg::t_out_beat solution_q [$];
    int fails = 0;
    int items = 0;
    int solves = 0;
    int beats_out = 0;
    int max_n = 0;
    int max_sweeps = 0;
    int conv_count = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= 10) $display("MISMATCH: %s", msg);
    endtask

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [31:0] row_value(input int i, input int n);
        longint acc, resid, diag;
        acc = 0;
        for (int j = 0; j < n; j++) begin
            if (j != i) acc += (longint'(a_mat[i][j]) * longint'(x_est[j])) >>> 16;
        end
        acc = sat32(acc);
        resid = sat32(longint'(b_vec[i]) - acc);
        diag = longint'(a_mat[i][i]);
        if (diag == 0) begin
            if (resid > 0) return 32'sh7FFF_FFFF;
            if (resid < 0) return 32'sh8000_0000;
            return 32'sh0;
        end
        return 32'(sat32((resid * 65536) / diag));
    endfunction

    function automatic longint change_add(input longint sum, input logic signed [31:0] oldv,
                                          input logic signed [31:0] newv);
        longint d, mag, sq;
        d = longint'(oldv) - longint'(newv);
        mag = (d < 0) ? -d : d;
        if (mag >= 64'sd2147483648) sq = 64'sd4294967295;
        else sq = (mag * mag) >>> 16;
        if (sq > 64'sd4294967295) sq = 64'sd4294967295;
        sum += sq;
        return (sum > 64'sd4294967295) ? 64'sd4294967295 : sum;
    endfunction

    function automatic int eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > 16) return 16;
        return int'(size_reg);
    endfunction

    // runs the hybrid sweeps and queues one expected beat per unknown
    task automatic predict_solution();
        int n, cap, sweeps;
        longint chg;
        bit conv;
        logic signed [31:0] odd_buf [8];
        hjgs_pkg::t_out_beat e;
        n = eff_size();
        cap = (limit_reg == 0) ? 1 : int'(limit_reg);
        for (int i = 0; i < 16; i++) x_est[i] = '0;
        sweeps = 0;
        conv = 1'b0;
        forever begin
            chg = 0;
            for (int i = 1; i < n; i += 2) begin
                odd_buf[i/2] = row_value(i, n);
                chg = change_add(chg, x_est[i], odd_buf[i/2]);
            end
            for (int i = 1; i < n; i += 2) x_est[i] = odd_buf[i/2];
            for (int i = 0; i < n; i += 2) begin
                logic signed [31:0] nv;
                nv = row_value(i, n);
                chg = change_add(chg, x_est[i], nv);
                x_est[i] = nv;
            end
            sweeps++;
            if (chg <= longint'({33'b0, thresh_reg})) begin
                conv = 1'b1;
                break;
            end
            if (sweeps >= cap) break;
        end
        for (int i = 0; i < n; i++) begin
            e.index = 4'(i);
            e.solution = x_est[i];
            e.last = (i == n - 1);
            e.converged = conv;
            e.sweeps_used = 16'(sweeps);
            solution_q.push_back(e);
        end
        if (n > max_n) max_n = n;
        if (sweeps > max_sweeps) max_sweeps = sweeps;
        if (conv) conv_count++;
        solves++;
    endtask

    task automatic send_beat(input hjgs_pkg::t_in_beat b);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        do @(posedge i_clk); while (o_in_stall);
        case (b.cmd)
            hjgs_pkg::CMD_LOAD_A: begin
                a_mat[b.row][b.col] = b.value;
                a_wr[b.row][b.col] = 1'b1;
                items++;
            end
            hjgs_pkg::CMD_LOAD_B: begin
                b_vec[b.row] = b.value;
                b_wr[b.row] = 1'b1;
                items++;
            end
            hjgs_pkg::CMD_SOLVE: begin
                predict_solution();
                items++;
            end
            default: ;
        endcase
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (solution_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
        drain_results();
        repeat (20) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hjgs_pkg::REG_SIZE:   size_reg = d[4:0];
            hjgs_pkg::REG_THRESH: thresh_reg = d[30:0];
            hjgs_pkg::REG_LIMIT:  limit_reg = d[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] entry_value(input bit on_diag, input int n, input bit wild);
        logic [31:0] mag;
        if (wild) return $urandom;
        if (on_diag) mag = $urandom_range(32'h1_0000, 32'h4_0000);
        else mag = $urandom_range(0, 16384 / n);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [31:0] rhs_value(input bit wild);
        logic [31:0] mag;
        if (wild) return $urandom;
        if ($urandom_range(0, 7) == 0) return '0;
        mag = $urandom_range(0, 32'h8_0000);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // loads some random entries, completes the system, then solves
    task automatic run_system(input bit wild);
        int n;
        hjgs_pkg::t_in_beat b;
        n = eff_size();
        repeat ($urandom_range(0, 2 * n)) begin
            b.cmd = $urandom_range(0, 1) ? hjgs_pkg::CMD_LOAD_A : hjgs_pkg::CMD_LOAD_B;
            b.row = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, n - 1));
            b.col = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, n - 1));
            b.value = (b.cmd == hjgs_pkg::CMD_LOAD_A) ? entry_value(b.row == b.col, n, wild)
                                                      : rhs_value(wild);
            send_beat(b);
        end
        if ($urandom_range(0, 5) == 0) begin
            b.cmd = CMD_NONE;
            b.row = 4'($urandom);
            b.col = 4'($urandom);
            b.value = $urandom;
            send_beat(b);
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (!a_wr[i][j]) begin
                    b.cmd = hjgs_pkg::CMD_LOAD_A;
                    b.row = 4'(i);
                    b.col = 4'(j);
                    b.value = entry_value(i == j, n, wild);
                    send_beat(b);
                end
            end
            if (!b_wr[i]) begin
                b.cmd = hjgs_pkg::CMD_LOAD_B;
                b.row = 4'(i);
                b.col = 4'($urandom);
                b.value = rhs_value(wild);
                send_beat(b);
            end
        end
        b.cmd = hjgs_pkg::CMD_SOLVE;
        b.row = 4'($urandom);
        b.col = 4'($urandom);
        b.value = $urandom;
        send_beat(b);
        if ($urandom_range(0, 2) == 0) drain_results();
    endtask

    // result side: random stall per beat, compare against oldest expectation
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            hjgs_pkg::t_out_beat e;
            beats_out++;
            if (solution_q.size() == 0) begin
                note_fail($sformatf("unexpected beat index %0d solution %h",
                                    o_out.index, o_out.solution));
            end else begin
                e = solution_q.pop_front();
                if (e.index !== o_out.index || e.solution !== o_out.solution ||
                    e.last !== o_out.last || e.converged !== o_out.converged ||
                    e.sweeps_used !== o_out.sweeps_used)
                    note_fail($sformatf({"exp idx %0d x %h last %b conv %b sweeps %0d, ",
                                         "got idx %0d x %h last %b conv %b sweeps %0d"},
                                        e.index, e.solution, e.last, e.converged,
                                        e.sweeps_used, o_out.index, o_out.solution,
                                        o_out.last, o_out.converged, o_out.sweeps_used));
            end
            if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
            stall_left = recv_burst ? 0 : $urandom_range(0, 5);
            out_stall <= (stall_left != 0);
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", solution_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int ph;
        hjgs_pkg::t_in_beat b;
        for (int i = 0; i < 16; i++) begin
            b_wr[i] = 1'b0;
            for (int j = 0; j < 16; j++) a_wr[i][j] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // size zero acts as one; single unknown settles within two sweeps
        write_reg(hjgs_pkg::REG_SIZE, 32'd0);
        write_reg(hjgs_pkg::REG_LIMIT, 32'd65535);
        for (int r = 0; r < DIR_ROWS; r++) begin
            b.cmd = DIR_TAB[r].cmd;
            b.row = DIR_TAB[r].row;
            b.col = DIR_TAB[r].col;
            b.value = DIR_TAB[r].value;
            send_beat(b);
            if (DIR_TAB[r].typed) begin
                if (solution_q[$].solution !== DIR_TAB[r].x0)
                    note_fail($sformatf("row %0d: table x %h, predicted %h", r,
                                        DIR_TAB[r].x0, solution_q[$].solution));
                solution_q[$].solution = DIR_TAB[r].x0;
            end
        end

        ph = 0;
        while (items < 320 || ph < 3) begin
            bit wild;
            int n;
            case (ph)
                0: begin
                    write_reg(hjgs_pkg::REG_SIZE, 32'd31);
                    write_reg(hjgs_pkg::REG_THRESH, 32'h7FFF_FFFF);
                    write_reg(hjgs_pkg::REG_LIMIT, 32'd0);
                end
                1: begin
                    write_reg(hjgs_pkg::REG_SIZE, 32'd16);
                    write_reg(hjgs_pkg::REG_THRESH, 32'd0);
                    write_reg(hjgs_pkg::REG_LIMIT, 32'd3);
                end
                default: begin
                    write_reg(hjgs_pkg::REG_SIZE,
                              $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                        : $urandom_range(1, 6));
                    case ($urandom_range(0, 3))
                        0: write_reg(hjgs_pkg::REG_THRESH, 32'd0);
                        1: write_reg(hjgs_pkg::REG_THRESH, $urandom_range(0, 64));
                        2: write_reg(hjgs_pkg::REG_THRESH, 32'h7FFF_FFFF);
                        default: write_reg(hjgs_pkg::REG_THRESH, {1'b0, 31'($urandom)});
                    endcase
                    n = eff_size();
                    if (n == 1 && $urandom_range(0, 1))
                        write_reg(hjgs_pkg::REG_LIMIT, 32'd65535);
                    else write_reg(hjgs_pkg::REG_LIMIT, n >= 10 ? $urandom_range(0, 6)
                                                                : $urandom_range(0, 40));
                end
            endcase
            send_burst = ($urandom_range(0, 3) == 0);
            wild = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) run_system(wild);
            ph++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("ran %0d load/solve beats, %0d solves (%0d converged), %0d result beats",
                 items, solves, conv_count, beats_out);
        $display("largest system %0d unknowns, most sweeps %0d", max_n, max_sweeps);
        if (fails == 0 && solution_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fails, solution_q.size());
            $display("Verification failed");
        end
        $finish;
    end
endmodule
